>>> rtl/aph_pkg.sv
// ----------------------------------------------------------------------------
// aph_pkg
// Shared constants, codes and control types for the animation playhead timer.
// ----------------------------------------------------------------------------
package aph_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int TS_W  = 20;
	localparam int SPD_W = 13;
	localparam int CFG_W = 32;
	localparam int POS_W = 32;
	localparam int CNT_W = 4;
	localparam int IDX_W = 2;
	localparam int FRAC_BITS = 8;
	localparam int D_W   = TS_W + SPD_W - FRAC_BITS;

	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_START   = 2'd1;
	localparam logic [1:0] FUNC_SETPLAY = 2'd2;

	localparam logic [1:0] MODE_ONCE = 2'd0;
	localparam logic [1:0] MODE_LOOP = 2'd1;
	localparam logic [1:0] MODE_PING = 2'd2;

	localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOW   = 2'd1;
	localparam logic [IDX_W-1:0] REG_HIGH  = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPEED = 2'd3;

	localparam logic [31:0] RANGE_HIGH_RST = 32'd3600000000;
	localparam logic [SPD_W-1:0] SPEED_RST = 13'd256;

	typedef struct packed {
		logic load;
		logic mul;
		logic eval;
		logic prep;
		logic div;
		logic fin;
	} aph_cmd_t;

	typedef struct packed {
		logic wrap;
		logic div_last;
	} aph_sts_t;

endpackage

>>> rtl/animation_playhead_timer.sv
// ----------------------------------------------------------------------------
// animation_playhead_timer
// Playhead counter with once, loop and back-and-forth modes and wrap count.
//
//   channel  signals                              direction  handshake
//   in       func, time_step, play_flag           in         in_valid/in_ready
//   out      position, end_count, playing,        out        out_valid/out_ready
//            reversed
//   cfg      cfg_index, cfg_data                  in         cfg_we, no wait
//
// one item at a time: accept, scale and evaluate, then commit the result;
// when the tick wraps or reflects, the restoring divider first runs over
// TW = max(TIME_BITS, 25) + 2 bits (34 at 32), one quotient bit a cycle
// asynchronous reset returns playhead 0, forward direction, playing set
// a finished result waits in the output register; the next item is taken
// meanwhile and holds before commit until that register is free
// ----------------------------------------------------------------------------
module animation_playhead_timer import aph_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [TS_W-1:0]   time_step,
	input  logic              play_flag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  position,
	output logic [CNT_W-1:0]  end_count,
	output logic              playing,
	output logic              reversed,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	aph_cmd_t cmd;
	aph_sts_t sts;

	aph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aph_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.func      (func),
		.time_step (time_step),
		.play_flag (play_flag),
		.cmd       (cmd),
		.sts       (sts),
		.position  (position),
		.end_count (end_count),
		.playing   (playing),
		.reversed  (reversed)
	);

endmodule

>>> rtl/aph_ctrl.sv
// ----------------------------------------------------------------------------
// aph_ctrl
// Sequencer for one item: scale, evaluate, optional division, commit.
// ----------------------------------------------------------------------------
module aph_ctrl import aph_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  aph_sts_t sts,
	output aph_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.wrap ? S_PREP : S_FIN;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MUL)
		else $error("accepted item did not start the sequence");

	a_rose_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result shown without a commit");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && sts.div_last |=> state_q == S_FIN)
		else $error("division did not end in commit");

	a_no_wrap_skip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL && !sts.wrap |=> state_q == S_FIN)
		else $error("division entered without a wrap");

endmodule

>>> rtl/aph_dp.sv
// ----------------------------------------------------------------------------
// aph_dp
// Datapath: configuration, playhead state, step scaling, restoring divider.
// ----------------------------------------------------------------------------
module aph_dp import aph_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [1:0]        func,
	input  logic [TS_W-1:0]   time_step,
	input  logic              play_flag,
	input  aph_cmd_t          cmd,
	output aph_sts_t          sts,
	output logic [POS_W-1:0]  position,
	output logic [CNT_W-1:0]  end_count,
	output logic              playing,
	output logic              reversed
);

	localparam int TB = TIME_BITS;
	localparam int TW = ((TB > D_W) ? TB : D_W) + 2;
	localparam int PW = (TB > POS_W) ? TB : POS_W;
	localparam int CW = $clog2(TW);
	localparam int PRW = TS_W + SPD_W;

	logic [1:0]          mode_q;
	logic [TB-1:0]       lo_q;
	logic [TB-1:0]       hi_q;
	logic [SPD_W-1:0]    speed_q;
	logic [TB-1:0]       ph_q;
	logic                rev_q;
	logic                play_q;

	logic [1:0]          func_q;
	logic [TS_W-1:0]     ts_q;
	logic                flag_q;
	logic [D_W-1:0]      d_q;
	logic signed [TW-1:0] t_q;
	logic                top_q;
	logic                wrap_q;
	logic [TB-1:0]       rem_q;
	logic [TW-1:0]       quo_q;
	logic [TB-1:0]       dur_q;
	logic [CW-1:0]       it_q;

	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                play_o_q;
	logic                rev_o_q;

	// step scaling
	logic                neg;
	logic                spd_zero;
	logic [SPD_W-1:0]    mag;
	logic [PRW-1:0]      prod;

	assign neg      = speed_q[SPD_W-1];
	assign spd_zero = (speed_q == '0);
	assign mag      = neg ? (~speed_q + SPD_W'(1)) : speed_q;
	assign prod     = PRW'(ts_q) * PRW'(mag);

	// evaluation
	logic signed [TW-1:0] lo_x;
	logic signed [TW-1:0] hi_x;
	logic signed [TW-1:0] ph_x;
	logic signed [TW-1:0] d_x;
	logic signed [TW-1:0] t_sum;
	logic                 sub;
	logic                 active;

	assign lo_x = $signed(TW'(lo_q));
	assign hi_x = $signed(TW'(hi_q));
	assign ph_x = $signed(TW'(ph_q));
	assign d_x  = $signed(TW'(d_q));
	assign sub  = (mode_q == MODE_PING) ? rev_q : neg;
	assign t_sum = sub ? (ph_x - d_x) : (ph_x + d_x);
	assign active = (func_q == FUNC_TICK) && play_q && !spd_zero && (hi_q > lo_q);

	always_comb begin
		sts.wrap = active && (mode_q inside {MODE_LOOP, MODE_PING})
			&& ((t_sum > hi_x) || (t_sum < lo_x));
		sts.div_last = (it_q == CW'(TW - 1));
	end

	// divider
	logic signed [TW-1:0] e_m1;
	logic [TB:0]          rem_sh;
	logic [TB:0]          rem_diff;
	logic                 ge;

	assign e_m1     = top_q ? (t_q - hi_x - TW'(1)) : (lo_x - t_q - TW'(1));
	assign rem_sh   = {rem_q, quo_q[TW-1]};
	assign rem_diff = rem_sh - {1'b0, dur_q};
	assign ge       = (rem_sh >= {1'b0, dur_q});

	// commit values
	logic [TB-1:0]    nph;
	logic [TB-1:0]    npos;
	logic             nrev;
	logic             nplay;
	logic [CNT_W-1:0] ncnt;
	logic [CNT_W-1:0] qsat;
	logic [TB-1:0]    t_tr;
	logic [TB-1:0]    lo_plus;
	logic [TB-1:0]    hi_minus;
	logic             end_high;
	logic [PW-1:0]    npos_x;

	assign qsat     = (quo_q >= TW'(CNT_MAX)) ? CNT_MAX : (quo_q[CNT_W-1:0] + CNT_W'(1));
	assign t_tr     = t_q[TB-1:0];
	assign lo_plus  = lo_q + rem_q + TB'(1);
	assign hi_minus = hi_q - rem_q - TB'(1);
	assign end_high = (top_q == !quo_q[0]);
	assign npos_x   = PW'(npos);

	always_comb begin
		nph   = ph_q;
		nrev  = rev_q;
		nplay = play_q;
		ncnt  = '0;
		npos  = ph_q;
		case (func_q)
			FUNC_TICK: begin
				if (play_q && !spd_zero) begin
					if (hi_q <= lo_q) begin
						npos = lo_q;
					end else begin
						case (mode_q)
							MODE_ONCE: begin
								nph = t_tr;
								if (!neg && (t_q >= hi_x)) begin
									nph   = hi_q;
									nplay = 1'b0;
									ncnt  = CNT_W'(1);
								end else if (neg && (t_q <= lo_x)) begin
									nph   = lo_q;
									nplay = 1'b0;
									ncnt  = CNT_W'(1);
								end
							end
							MODE_LOOP: begin
								if (wrap_q) begin
									nph  = top_q ? lo_plus : hi_minus;
									ncnt = qsat;
								end else begin
									nph = t_tr;
								end
							end
							MODE_PING: begin
								if (wrap_q) begin
									nph  = end_high ? hi_minus : lo_plus;
									nrev = end_high;
									ncnt = qsat;
								end else begin
									nph = t_tr;
								end
							end
							default: begin
								nph = ph_q;
							end
						endcase
						npos = nph;
					end
				end
			end
			FUNC_START: begin
				nph   = neg ? hi_q : lo_q;
				nplay = 1'b1;
				npos  = nph;
			end
			FUNC_SETPLAY: begin
				nplay = flag_q;
			end
			default: begin
				nph = ph_q;
			end
		endcase
	end

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ONCE;
			lo_q    <= '0;
			hi_q    <= TB'(RANGE_HIGH_RST);
			speed_q <= SPEED_RST;
			ph_q    <= '0;
			rev_q   <= 1'b0;
			play_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[1:0];
					REG_LOW:   lo_q    <= TB'(cfg_data);
					REG_HIGH:  hi_q    <= TB'(cfg_data);
					REG_SPEED: speed_q <= cfg_data[SPD_W-1:0];
					default: begin
						mode_q <= mode_q;
					end
				endcase
			end
			if (cmd.fin) begin
				ph_q   <= nph;
				rev_q  <= nrev;
				play_q <= nplay;
			end
		end
	end

	// working and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			ts_q   <= time_step;
			flag_q <= play_flag;
		end
		if (cmd.mul) begin
			d_q <= prod[PRW-1:FRAC_BITS];
		end
		if (cmd.eval) begin
			t_q    <= t_sum;
			top_q  <= (t_sum > hi_x);
			wrap_q <= sts.wrap;
		end
		if (cmd.prep) begin
			quo_q <= e_m1;
			rem_q <= '0;
			dur_q <= hi_q - lo_q;
			it_q  <= '0;
		end
		if (cmd.div) begin
			rem_q <= ge ? rem_diff[TB-1:0] : rem_sh[TB-1:0];
			quo_q <= {quo_q[TW-2:0], ge};
			it_q  <= it_q + CW'(1);
		end
		if (cmd.fin) begin
			pos_q    <= npos_x[POS_W-1:0];
			cnt_q    <= ncnt;
			play_o_q <= nplay;
			rev_o_q  <= nrev;
		end
	end

	assign position  = pos_q;
	assign end_count = cnt_q;
	assign playing   = play_o_q;
	assign reversed  = rev_o_q;

endmodule
